FILE: rtl/core/fermat_primality_tester_defines.svh
// Assertion macros used by the top-level RTL
`ifndef FERMAT_PRIMALITY_TESTER_DEFINES_SVH
`define FERMAT_PRIMALITY_TESTER_DEFINES_SVH

// Property that must hold from the edge after a condition
`define FPT_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
    else $error("assertion failed");

// Property that must hold in the same cycle
`define FPT_ASSERT_NOW(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/fpt_pkg.sv
`default_nettype none
package fpt_pkg;
  localparam int NumberWidthDef = 64;
  localparam logic [7:0]  RoundsReset = 8'd100;
  localparam logic [31:0] LfsrTaps    = 32'h8020_0003;
  localparam logic [31:0] LfsrSeed    = 32'h0000_0001;

  // Modular unit operation codes
  typedef enum logic [1:0] {
    OP_MOD = 2'd0,
    OP_MUL = 2'd1
  } mod_op_t;

  // Request from the sequencer to the modular unit
  typedef struct packed {
    logic    go;
    mod_op_t op;
  } mod_req_t;
endpackage
`default_nettype wire

FILE: rtl/core/fermat_primality_tester.sv
`default_nettype none
// Channel  | Ports                               | Transfer
// input    | start, busy, in_candidate           | start && !busy
// result   | out_valid, out_probably_prime       | out_valid (one cycle)
// config   | cfg_valid, cfg_ready, cfg_round_count | cfg_valid && cfg_ready
// Each modular operation (reduce or multiply) runs in one bit-serial unit of
// SW = max(NW, 32) steps; a round does one base reduction, NW squares and up to
// NW-1 multiplies.
// Small candidates (p <= 2) or zero rounds go straight to the result; a failing
// round ends the item early.
// Synchronous active-low reset; round_count resets to 100, LFSR to 1.
// The result cannot be stalled; busy holds off new items until it is out.
module fermat_primality_tester #(
  parameter int NW = fpt_pkg::NumberWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_candidate,
  output logic             out_valid,
  output logic             out_probably_prime,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_round_count
);
  `include "fermat_primality_tester_defines.svh"

  localparam int EW = $clog2(NW);

  typedef enum logic [2:0] {
    S_IDLE, S_BASE, S_WBASE, S_MUL, S_WMUL, S_SQR, S_WSQR, S_DONE
  } state_t;

  state_t        state_r;
  logic [7:0]    rounds_r, rleft_r;
  logic [31:0]   lfsr_r;
  logic [NW-1:0] p_r, base_r, acc_r, m_r;
  logic [EW-1:0] bit_r;
  logic          verdict_r, out_valid_r;

  fpt_pkg::mod_req_t req;
  logic [NW-1:0] mx, my, mr;
  logic          mdone;
  logic [31:0]   lfsr_adv;
  logic [NW-1:0] p_in, e_val;

  assign p_in  = in_candidate[NW-1:0];
  assign e_val = p_r - NW'(1);
  assign lfsr_adv = lfsr_r[0] ? ({1'b0, lfsr_r[31:1]} ^ fpt_pkg::LfsrTaps)
                              : {1'b0, lfsr_r[31:1]};

  fpt_modunit #(.NW(NW)) u_mod (
    .clk(clk), .rst_n(rst_n), .req(req), .x(mx), .y(my), .m(m_r),
    .dvd(lfsr_adv), .r(mr), .done(mdone)
  );

  // Modular unit request decode
  always_comb begin
    req.go = 1'b0;
    req.op = fpt_pkg::OP_MUL;
    mx = acc_r;
    my = base_r;
    unique case (state_r)
      S_BASE: begin
        req.go = 1'b1;
        req.op = fpt_pkg::OP_MOD;
      end
      S_MUL: begin
        req.go = 1'b1;
      end
      S_SQR: begin
        req.go = 1'b1;
        mx = base_r;
      end
      default: ;
    endcase
  end

  // Sequencer: LSB-first square-and-multiply over the exponent p-1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rounds_r    <= fpt_pkg::RoundsReset;
      lfsr_r      <= fpt_pkg::LfsrSeed;
      out_valid_r <= 1'b0;
      verdict_r   <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE);
      if (cfg_valid && cfg_ready) begin
        rounds_r <= cfg_round_count;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            p_r       <= p_in;
            m_r       <= p_in - NW'(2);
            rleft_r   <= rounds_r;
            verdict_r <= (p_in >= NW'(2));
            if (p_in <= NW'(2) || rounds_r == 8'd0) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_BASE;
            end
          end
        end
        S_BASE: begin
          lfsr_r  <= lfsr_adv;
          state_r <= S_WBASE;
        end
        S_WBASE: begin
          if (mdone) begin
            base_r  <= mr + NW'(2);
            m_r     <= p_r;
            acc_r   <= NW'(1);
            bit_r   <= '0;
            state_r <= e_val[0] ? S_MUL : S_SQR;
          end
        end
        S_MUL: state_r <= S_WMUL;
        S_WMUL: begin
          if (mdone) begin
            acc_r   <= mr;
            state_r <= S_SQR;
          end
        end
        S_SQR: state_r <= S_WSQR;
        S_WSQR: begin
          if (mdone) begin
            base_r <= mr;
            if (bit_r == EW'(NW - 1)) begin
              if (acc_r != NW'(1)) begin
                verdict_r <= 1'b0;
                state_r   <= S_DONE;
              end else if (rleft_r == 8'd1) begin
                state_r <= S_DONE;
              end else begin
                rleft_r <= rleft_r - 8'd1;
                m_r     <= p_r - NW'(2);
                state_r <= S_BASE;
              end
            end else begin
              bit_r   <= bit_r + 1'b1;
              state_r <= e_val[bit_r + 1'b1] ? S_MUL : S_SQR;
            end
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign cfg_ready          = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_probably_prime = verdict_r;

  `FPT_ASSERT_NEXT(a_done_valid, clk, rst_n, state_r == S_DONE, out_valid)
  `FPT_ASSERT_NOW(a_valid_idle, clk, rst_n, out_valid, state_r == S_IDLE)
  `FPT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `FPT_ASSERT_NOW(a_rounds_left, clk, rst_n, state_r == S_BASE, rleft_r != 8'd0)
endmodule
`default_nettype wire

FILE: rtl/core/fpt_modunit.sv
`default_nettype none
// Bit-serial modular unit, SW = max(NW, 32) steps per operation.
// OP_MUL: r = x*y mod m, one multiplier bit per cycle (double-and-add).
// OP_MOD: r = dvd mod m, one dividend bit per cycle (shift-in and
// conditional subtract). Requires x < m for OP_MUL.
module fpt_modunit #(
  parameter int NW = fpt_pkg::NumberWidthDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fpt_pkg::mod_req_t req,
  input  wire logic [NW-1:0]     x,
  input  wire logic [NW-1:0]     y,
  input  wire logic [NW-1:0]     m,
  input  wire logic [31:0]       dvd,
  output logic [NW-1:0]          r,
  output logic                   done
);
  localparam int SW = (NW > 32) ? NW : 32;
  localparam int CW = $clog2(SW + 1);

  logic [NW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] sh_r, sh_nxt;
  logic [NW-1:0] xv_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  fpt_pkg::mod_op_t op_r;

  logic [NW:0]   dbl, s1;
  logic [NW-1:0] stepped;
  logic [NW:0]   sum;

  // One step of either operation
  always_comb begin
    if (op_r == fpt_pkg::OP_MUL) begin
      dbl = {acc_r, 1'b0};
    end else begin
      dbl = {acc_r, sh_r[SW-1]};
    end
    s1 = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum = s1 + {1'b0, xv_r};
    if (op_r == fpt_pkg::OP_MUL && sh_r[SW-1]) begin
      stepped = (sum >= {1'b0, m}) ? NW'(sum - {1'b0, m}) : NW'(sum);
    end else begin
      stepped = NW'(s1);
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.go) begin
      acc_nxt  = '0;
      sh_nxt   = (req.op == fpt_pkg::OP_MUL) ? SW'(y) : SW'(dvd);
      cnt_nxt  = CW'(SW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = stepped;
      sh_nxt  = {sh_r[SW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    if (req.go) begin
      xv_r <= x;
      op_r <= req.op;
    end
  end

  assign r    = acc_r;
  assign done = done_r;
endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_candidate;
  logic        out_valid;
  logic        out_probably_prime;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_round_count;

  fermat_primality_tester u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_candidate       (in_candidate),
    .out_valid          (out_valid),
    .out_probably_prime (out_probably_prime),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_round_count    (cfg_round_count)
  );

  // 20 ns clock
  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Predictor state: round count and witness LFSR
  logic [7:0]  pred_rounds;
  logic [31:0] pred_lfsr;
  bit          verdict_q[$];
  int          n_errors;
  int          n_items;
  int          n_results;

  // Directed row: round count to set, candidate, optional typed-in verdict
  typedef struct {
    logic [7:0]  rounds;
    logic [63:0] cand;
    bit          known;
    bit          verdict;
  } dir_row_t;

  localparam int NumDir = 22;
  dir_row_t dir_tab [NumDir] = '{
    '{8'd100, 64'd0, 1'b1, 1'b0},
    '{8'd100, 64'd1, 1'b1, 1'b0},
    '{8'd100, 64'd2, 1'b1, 1'b1},
    '{8'd100, 64'd4, 1'b0, 1'b0},
    '{8'd100, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{8'd100, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
    '{8'd255, 64'd1000, 1'b0, 1'b0},
    '{8'd255, 64'd1, 1'b1, 1'b0},
    '{8'd255, 64'd2, 1'b1, 1'b1},
    '{8'd0, 64'd7, 1'b1, 1'b1},
    '{8'd0, 64'd12345678, 1'b1, 1'b1},
    '{8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
    '{8'd0, 64'd0, 1'b1, 1'b0},
    '{8'd2, 64'd3, 1'b0, 1'b0},
    '{8'd2, 64'd5, 1'b0, 1'b0},
    '{8'd2, 64'd9, 1'b0, 1'b0},
    '{8'd2, 64'd561, 1'b0, 1'b0},
    '{8'd2, 64'h1FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{8'd2, 64'hFFFF_FFFF_FFFF_FFC5, 1'b0, 1'b0},
    '{8'd1, 64'd4294967291, 1'b0, 1'b0},
    '{8'd1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0},
    '{8'd1, 64'd6601, 1'b0, 1'b0}
  };

  logic [63:0] small_primes [6]  = '{64'd3, 64'd13, 64'd101, 64'd7919, 64'd65521, 64'd65537};
  logic [63:0] carmichaels  [7]  = '{64'd561, 64'd1105, 64'd1729, 64'd2465, 64'd2821,
                                    64'd6601, 64'd8911};
  logic [63:0] big_primes   [3]  = '{64'h1FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
                                    64'd4294967291};
  logic [7:0]  phase_rounds [4]  = '{8'd1, 8'd2, 8'd3, 8'd1};

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    b = b % m;
    while (e != 64'd0) begin
      if (e[0]) acc = mul_mod(acc, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // Fermat verdict for one candidate; advances the predictor LFSR
  function automatic bit fermat_verdict(logic [63:0] p);
    logic [63:0] base;
    if (p < 64'd2) return 1'b0;
    if (p == 64'd2) return 1'b1;
    for (int r = 0; r < int'(pred_rounds); r++) begin
      pred_lfsr = (pred_lfsr >> 1) ^ (pred_lfsr[0] ? fpt_pkg::LfsrTaps : 32'd0);
      base = {32'd0, pred_lfsr} % (p - 64'd2) + 64'd2;
      if (pow_mod(base, p - 64'd1, p) != 64'd1) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Round count write, only while idle
  task automatic write_rounds(logic [7:0] v);
    wait (verdict_q.size() == 0);
    repeat (8) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_round_count <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    pred_rounds = v;
  endtask

  // One candidate transfer; start is left high for the caller to drop
  task automatic send_candidate(logic [63:0] c, bit known, bit verdict);
    bit pv;
    start        <= 1'b1;
    in_candidate <= c;
    do @(posedge clk); while (busy);
    pv = fermat_verdict(c);
    if (known && pv != verdict) begin
      $error("typed-in verdict for %0d is %0b, predictor says %0b", c, verdict, pv);
      n_errors++;
    end
    verdict_q = {verdict_q, known ? verdict : pv};
    n_items++;
  endtask

  // Bursts with random gaps between them
  int burst_left;
  task automatic pace;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 5);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [63:0] pick_candidate();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 64'($urandom_range(0, 65535));
      4, 5:       return {$urandom, $urandom};
      6:          return small_primes[$urandom_range(0, 5)];
      7:          return carmichaels[$urandom_range(0, 6)];
      8:          return big_primes[$urandom_range(0, 2)];
      default:    return 64'($urandom_range(0, 3));
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (verdict_q.size() == 0) begin
        $error("result with no item pending: probably_prime=%0b", out_probably_prime);
        n_errors++;
      end else begin
        bit want;
        want = verdict_q.pop_front();
        if (out_probably_prime !== want) begin
          $error("probably_prime expected %0b actual %0b", want, out_probably_prime);
          n_errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    start           <= 1'b0;
    in_candidate    <= 64'd0;
    cfg_valid       <= 1'b0;
    cfg_round_count <= 8'd0;
    rst_n           <= 1'b0;
    pred_rounds = fpt_pkg::RoundsReset;
    pred_lfsr   = fpt_pkg::LfsrSeed;
    n_errors = 0; n_items = 0; n_results = 0; burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < NumDir; i++) begin
      if (dir_tab[i].rounds != pred_rounds) begin
        start <= 1'b0;
        write_rounds(dir_tab[i].rounds);
      end
      send_candidate(dir_tab[i].cand, dir_tab[i].known, dir_tab[i].verdict);
      pace();
    end

    // Random phases, each under its own round count
    for (int ph = 0; ph < 4; ph++) begin
      start <= 1'b0;
      write_rounds(phase_rounds[ph]);
      for (int k = 0; k < 20; k++) begin
        send_candidate(pick_candidate(), 1'b0, 1'b0);
        pace();
      end
    end
    start <= 1'b0;

    wait (verdict_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("Tested %0d candidates (%0d verdicts) over round counts 0, 1, 2, 3, 100, 255",
             n_items, n_results);
    $display("including small values, Carmichael numbers and 64-bit primes");
    if (n_errors == 0 && verdict_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #500_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/fpt_pkg.sv
rtl/core/fpt_modunit.sv
rtl/core/fermat_primality_tester.sv
tb/tb.sv
